[src/crc8fd_pkg.sv]
`timescale 1ns / 1ps

package crc8fd_pkg;

   localparam logic [7:0] CRC_POLY      = 8'h07;
   localparam logic [7:0] CRC_MSB       = 8'h80;
   localparam logic [7:0] CRC_INIT      = 8'h00;
   localparam logic [7:0] HEADER_RESET  = 8'hAA;
   localparam logic [5:0] MAXLEN_RESET  = 6'd32;
   localparam int         RESULT_CAP    = 32;
   localparam int         LEN_W         = 6;
   localparam int         BIDX_W        = 5;

   typedef enum logic [0:0] {
      CSR_HEADER_BYTE = 1'b0,
      CSR_MAX_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CMD    = 3'd1,
      PH_LEN    = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC    = 3'd4
   } parse_phase_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FETCH = 2'd1,
      BK_LOAD  = 2'd2
   } back_state_type;

   // descriptor of a frame that passed its CRC
   typedef struct packed {
      logic             push;
      logic [7:0]       cmd;
      logic [LEN_W-1:0] len;
   } push_type;

   typedef struct packed {
      logic             valid;
      logic [7:0]       cmd;
      logic [LEN_W-1:0] len;
   } head_type;

   // MSB-first CRC-8 over one byte, no final xor
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

[src/crc8fd_front.sv]
`timescale 1ns / 1ps

module crc8fd_front #(
   parameter int MAX_PAYLOAD = 32,
   parameter int IDX_W       = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_rx_byte,
   input  logic                     csr_valid,
   input  logic                     csr_index,
   input  logic [7:0]               csr_data,
   input  logic                     q_full,
   output logic                     wr_en,
   output logic [IDX_W-1:0]         wr_idx,
   output logic [7:0]               wr_data,
   output crc8fd_pkg::push_type     push
);
   import crc8fd_pkg::*;

   localparam int LIM_CAP = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;

   parse_phase_type  phase_ff, phase_in;
   logic [7:0]       header_ff, header_in;
   logic [LEN_W-1:0] maxlen_ff, maxlen_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       crc_ff, crc_in;

   logic             accept;
   logic [7:0]       crc_next;
   logic [LEN_W-1:0] limit;
   logic             too_long;
   logic [LEN_W-1:0] fill_inc;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign crc_next  = crc8_step(crc_ff, req_rx_byte);
   assign limit     = (maxlen_ff > LEN_W'(LIM_CAP)) ? LEN_W'(LIM_CAP) : maxlen_ff;
   assign too_long  = req_rx_byte > {2'b00, limit};
   assign fill_inc  = fill_ff + LEN_W'(1);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_CMD:  phase_in = PH_LEN;
            PH_LEN: begin
               if (too_long) begin
                  phase_in = PH_HEADER;
               end else if (req_rx_byte == 8'h00) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: phase_in = (fill_inc >= len_ff) ? PH_CRC : PH_DATA;
            PH_CRC:  phase_in = PH_HEADER;
            default: phase_in = (req_rx_byte == header_ff) ? PH_CMD : PH_HEADER;
         endcase
      end
   end

   always_comb begin
      header_in = header_ff;
      maxlen_in = maxlen_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      wr_en     = 1'b0;
      push      = '0;
      push.cmd  = cmd_ff;
      push.len  = len_ff;
      if (csr_valid) begin
         if (csr_index == CSR_HEADER_BYTE) begin
            header_in = csr_data;
         end else begin
            maxlen_in = csr_data[LEN_W-1:0];
         end
      end
      if (accept) begin
         case (phase_ff)
            PH_CMD: begin
               cmd_in = req_rx_byte;
               crc_in = crc_next;
            end
            PH_LEN: begin
               if (!too_long) begin
                  len_in  = req_rx_byte[LEN_W-1:0];
                  crc_in  = crc_next;
                  fill_in = '0;
               end
            end
            PH_DATA: begin
               wr_en   = 1'b1;
               crc_in  = crc_next;
               fill_in = fill_inc;
            end
            PH_CRC: begin
               push.push = (req_rx_byte == crc_ff);
            end
            default: begin
               if (req_rx_byte == header_ff) begin
                  crc_in = crc8_step(CRC_INIT, req_rx_byte);
               end
            end
         endcase
      end
   end

   assign wr_idx  = IDX_W'(fill_ff);
   assign wr_data = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= HEADER_RESET;
         maxlen_ff <= MAXLEN_RESET;
         cmd_ff    <= '0;
         len_ff    <= '0;
         fill_ff   <= '0;
         crc_ff    <= CRC_INIT;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         maxlen_ff <= maxlen_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         fill_ff   <= fill_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

[src/crc8fd_queue.sv]
`timescale 1ns / 1ps

module crc8fd_queue #(
   parameter int IDX_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [7:0]               wr_data,
   input  crc8fd_pkg::push_type     push,
   output logic                     q_full,
   input  logic                     pop,
   input  logic [IDX_W-1:0]         rd_idx,
   output logic [7:0]               rd_data,
   output crc8fd_pkg::head_type     head
);
   import crc8fd_pkg::*;

   localparam int DEPTH = 2 << IDX_W;

   // one payload bank per descriptor slot; the front fills the bank at wr_ptr
   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [7:0]       cmd_ff [2];
   logic [LEN_W-1:0] len_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign q_full = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push.push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_ptr_ff, wr_idx}] <= wr_data;
      end
      rd_data_ff <= mem[{rd_ptr_ff, rd_idx}];
      if (push.push) begin
         cmd_ff[wr_ptr_ff] <= push.cmd;
         len_ff[wr_ptr_ff] <= push.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rd_data    = rd_data_ff;
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = cmd_ff[rd_ptr_ff];
   assign head.len   = len_ff[rd_ptr_ff];

endmodule

[src/crc8fd_back.sv]
`timescale 1ns / 1ps

module crc8fd_back #(
   parameter int IDX_W = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  crc8fd_pkg::head_type                head,
   output logic                                pop,
   output logic [IDX_W-1:0]                    rd_idx,
   input  logic [7:0]                          rd_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_frame_command,
   output logic [crc8fd_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic                                rsp_has_data,
   output logic [crc8fd_pkg::BIDX_W-1:0]       rsp_byte_index,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_last
);
   import crc8fd_pkg::*;

   back_state_type    state_ff, state_in;
   logic [BIDX_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [7:0]        cmd_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              has_ff;
   logic [BIDX_W-1:0] bidx_ff;
   logic [7:0]        data_ff;
   logic              last_ff;

   logic              can_load;
   logic              is_last;
   logic              empty;
   logic              emit;

   assign can_load = !valid_ff || rsp_ready;
   assign empty    = (head.len == '0);
   assign is_last  = empty || ((LEN_W'(idx_ff) + LEN_W'(1)) == head.len);
   assign rd_idx   = IDX_W'(idx_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  state_in = head.valid ? BK_FETCH : BK_IDLE;
         BK_FETCH: state_in = BK_LOAD;
         BK_LOAD: begin
            if (can_load) begin
               state_in = is_last ? BK_IDLE : BK_FETCH;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      emit     = (state_ff == BK_LOAD) && can_load;
      pop      = emit && is_last;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (emit) begin
         idx_in   = is_last ? '0 : idx_ff + BIDX_W'(1);
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // result word; hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (emit) begin
         cmd_ff  <= head.cmd;
         len_ff  <= head.len;
         has_ff  <= !empty;
         bidx_ff <= idx_ff;
         data_ff <= empty ? 8'h00 : rd_data;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_command  = cmd_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_has_data       = has_ff;
   assign rsp_byte_index     = bidx_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_last           = last_ff;

endmodule

[src/crc8_frame_deframer.sv]
`timescale 1ns / 1ps
// channel | handshake           | payload
// req     | req_valid/req_ready | req_rx_byte
// rsp     | rsp_valid/rsp_ready | frame_command, payload_length, has_data, byte_index,
//         |                     | data_byte, last
// csr     | csr_valid/csr_ready | csr_index, csr_data
//
// The parser takes one received byte per cycle while req_ready is high. Each result word
// passes the replay sequencer's payload read and then the load of the output word, and each
// frame first picks up its descriptor; an empty frame is one word.
// Two descriptor slots with a payload bank each sit between parser and sequencer;
// req_ready drops while both slots hold frames not yet replayed.
// Reset clears control state, sets header_byte to 0xAA and max_length to 32.

module crc8_frame_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_frame_command,
   output logic [crc8fd_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic                                rsp_has_data,
   output logic [crc8fd_pkg::BIDX_W-1:0]       rsp_byte_index,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [7:0]                          csr_data
);
   import crc8fd_pkg::*;

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic             q_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_data;
   push_type         push;
   logic             pop;
   logic [IDX_W-1:0] rd_idx;
   logic [7:0]       rd_data;
   head_type         head;

   assign csr_ready = 1'b1;

   crc8fd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .push        (push)
   );

   crc8fd_queue #(
      .IDX_W (IDX_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .push    (push),
      .q_full  (q_full),
      .pop     (pop),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .head    (head)
   );

   crc8fd_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rd_idx             (rd_idx),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_has_data       (rsp_has_data),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last)
   );

endmodule

[src/crc8fd_checker.sv]
`timescale 1ns / 1ps

module crc8fd_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [7:0]                          rsp_frame_command,
   input  logic [crc8fd_pkg::LEN_W-1:0]        rsp_payload_length,
   input  logic                                rsp_has_data,
   input  logic [crc8fd_pkg::BIDX_W-1:0]       rsp_byte_index,
   input  logic [7:0]                          rsp_data_byte,
   input  logic                                rsp_last
);
   import crc8fd_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_command)
         && $stable(rsp_payload_length) && $stable(rsp_byte_index)
         && $stable(rsp_data_byte) && $stable(rsp_last) && $stable(rsp_has_data))
      else $error("rsp word changed while stalled");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_last && rsp_payload_length == '0
         && rsp_byte_index == '0 && rsp_data_byte == 8'h00)
      else $error("empty-frame word malformed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |-> LEN_W'(rsp_byte_index) < rsp_payload_length)
      else $error("byte index beyond payload length");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |->
         rsp_last == (LEN_W'(rsp_byte_index) + LEN_W'(1) == rsp_payload_length))
      else $error("last flag on wrong byte");

   // words of one frame come in index order
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_has_data && !rsp_last ##1 rsp_valid |->
         rsp_has_data && rsp_byte_index == $past(rsp_byte_index) + BIDX_W'(1))
      else $error("payload words out of order");

endmodule

bind crc8_frame_deframer crc8fd_checker u_checker (.*);

[dv/crc8_frame_deframer_test.sv]
`timescale 1ns / 1ps

module crc8_frame_deframer_test;
   import crc8fd_pkg::*;

   typedef struct packed {
      logic [7:0]        cmd;
      logic [LEN_W-1:0]  len;
      logic              has_data;
      logic [BIDX_W-1:0] idx;
      logic [7:0]        data;
      logic              last;
   } replay_word_type;

   typedef enum {TAIL_GOOD, TAIL_BAD, TAIL_NONE} tail_kind_type;

   localparam int SETTLE_CYCLES = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_frame_command;
   logic [LEN_W-1:0]    rsp_payload_length;
   logic                rsp_has_data;
   logic [BIDX_W-1:0]   rsp_byte_index;
   logic [7:0]          rsp_data_byte;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [7:0]          csr_data = 8'h00;

   // predictor state
   logic [7:0]          cfg_header = HEADER_RESET;
   logic [LEN_W-1:0]    cfg_max_len = MAXLEN_RESET;
   parse_phase_type     rx_phase = PH_HEADER;
   logic [7:0]          rx_cmd = 8'h00;
   logic [LEN_W-1:0]    rx_len = '0;
   logic [LEN_W-1:0]    fill_count = '0;
   logic [7:0]          crc_acc = 8'h00;
   logic [7:0]          payload_buf [RESULT_CAP];

   replay_word_type     words_due [$];
   logic [7:0]          pending_bytes [$];
   logic [7:0]          frame_buf [$];
   int                  bytes_queued = 0;
   int                  fail_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_request = 0;
   int                  hold_left = 0;
   logic                req_took = 1'b0;

   crc8_frame_deframer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_has_data       (rsp_has_data),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
   endfunction

   // max_length saturates at the result capacity
   function automatic int eff_limit();
      int lim;
      lim = cfg_max_len;
      if (lim > RESULT_CAP) lim = RESULT_CAP;
      return lim;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      replay_word_type w;
      case (rx_phase)
         PH_CMD: begin
            rx_cmd = b;
            crc_acc = crc8_next(crc_acc, b);
            rx_phase = PH_LEN;
         end
         PH_LEN: begin
            if (int'(b) > eff_limit()) begin
               rx_phase = PH_HEADER;
            end else begin
               rx_len = b[LEN_W-1:0];
               crc_acc = crc8_next(crc_acc, b);
               fill_count = '0;
               if (b == 8'h00) rx_phase = PH_CRC;
               else rx_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            payload_buf[fill_count[BIDX_W-1:0]] = b;
            crc_acc = crc8_next(crc_acc, b);
            fill_count = fill_count + 1'b1;
            if (fill_count >= rx_len) rx_phase = PH_CRC;
         end
         PH_CRC: begin
            if (b == crc_acc) begin
               if (rx_len == 0) begin
                  w = '{cmd: rx_cmd, len: '0, has_data: 1'b0, idx: '0, data: 8'h00,
                        last: 1'b1};
                  words_due.push_back(w);
               end else begin
                  for (int i = 0; i < rx_len; i++) begin
                     w = '{cmd: rx_cmd, len: rx_len, has_data: 1'b1,
                           idx: i[BIDX_W-1:0], data: payload_buf[i],
                           last: (i + 1 == rx_len)};
                     words_due.push_back(w);
                  end
               end
            end
            rx_phase = PH_HEADER;
         end
         default: begin
            if (b == cfg_header) begin
               crc_acc = crc8_next(CRC_INIT, b);
               rx_phase = PH_CMD;
            end else begin
               rx_phase = PH_HEADER;
            end
         end
      endcase
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_word();
      replay_word_type want;
      if (words_due.size() == 0) begin
         $error("frame word with none expected: command %0h index %0d",
                rsp_frame_command, rsp_byte_index);
         fail_count++;
      end else begin
         want = words_due.pop_front();
         check_field("frame_command", want.cmd, rsp_frame_command);
         check_field("payload_length", want.len, rsp_payload_length);
         check_field("has_data", want.has_data, rsp_has_data);
         check_field("byte_index", want.idx, rsp_byte_index);
         check_field("data_byte", want.data, rsp_data_byte);
         check_field("last", want.last, rsp_last);
      end
   endtask

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && req_ready;
         if (rsp_valid && rsp_ready) check_word();
         if (req_took) parse_rx_byte(req_rx_byte);
      end
   end

   // driver: hold the word until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic open_frame(input logic [7:0] cmd, input int len);
      frame_buf.delete();
      frame_buf.push_back(cfg_header);
      frame_buf.push_back(cmd);
      frame_buf.push_back(8'(len));
   endtask

   task automatic add_payload(input int len);
      repeat (len) begin
         if ($urandom_range(7) == 0) frame_buf.push_back(cfg_header);
         else frame_buf.push_back(8'($urandom));
      end
   endtask

   task automatic close_frame(input tail_kind_type tail);
      logic [7:0] c;
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc8_next(c, frame_buf[i]);
      if (tail == TAIL_BAD) c ^= 8'(1 << $urandom_range(7));
      if (tail != TAIL_NONE) frame_buf.push_back(c);
      foreach (frame_buf[i]) push_byte(frame_buf[i]);
      frame_buf.delete();
   endtask

   function automatic logic [7:0] random_cmd();
      if ($urandom_range(7) == 0) return cfg_header;
      return 8'($urandom);
   endfunction

   task automatic queue_traffic(input int n_bytes);
      int goal, lim, len, kind, r;
      logic [7:0] nb;
      goal = bytes_queued + n_bytes;
      while (bytes_queued < goal) begin
         lim = eff_limit();
         kind = $urandom_range(99);
         r = $urandom_range(99);
         if (r < 8) len = lim;
         else if (r < 16) len = 0;
         else len = $urandom_range((lim < 6) ? lim : 6);
         if (kind < 65) begin
            open_frame(random_cmd(), len);
            add_payload(len);
            close_frame(TAIL_GOOD);
         end else if (kind < 77) begin
            open_frame(random_cmd(), len);
            add_payload(len);
            close_frame(TAIL_BAD);
         end else if (kind < 85) begin
            open_frame(random_cmd(), $urandom_range(255, lim + 1));
            close_frame(TAIL_NONE);
         end else if (kind < 90 && lim > 0) begin
            // cut the frame short; the next frame's bytes get swallowed
            len = $urandom_range(lim, 1);
            open_frame(random_cmd(), len);
            add_payload($urandom_range(len - 1));
            close_frame(TAIL_NONE);
         end else begin
            repeat ($urandom_range(3, 1)) begin
               do nb = 8'($urandom); while (nb == cfg_header);
               push_byte(nb);
            end
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_HEADER_BYTE) cfg_header = value;
      else cfg_max_len = value[LEN_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || words_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset config
      push_byte(8'h00);
      push_byte(8'hFF);
      open_frame(8'h00, 0);
      close_frame(TAIL_GOOD);
      open_frame(8'hFF, 1);
      frame_buf.push_back(8'hFF);
      close_frame(TAIL_GOOD);
      open_frame(8'h5A, 1);
      frame_buf.push_back(8'h00);
      close_frame(TAIL_BAD);
      open_frame(8'h11, RESULT_CAP + 1);
      close_frame(TAIL_NONE);
      // header value inside the frame is plain data
      open_frame(cfg_header, 2);
      frame_buf.push_back(cfg_header);
      frame_buf.push_back(cfg_header);
      close_frame(TAIL_GOOD);
      drain();

      // max_length above the cap saturates
      write_reg(CSR_HEADER_BYTE, 8'h00);
      write_reg(CSR_MAX_LENGTH, 8'hFF);
      queue_traffic(120);
      drain();

      send_idle_pct = 78;
      write_reg(CSR_HEADER_BYTE, 8'hFF);
      write_reg(CSR_MAX_LENGTH, 8'h00);
      queue_traffic(60);
      drain();

      send_idle_pct = 0;
      stall_pct = 78;
      write_reg(CSR_HEADER_BYTE, 8'($urandom));
      write_reg(CSR_MAX_LENGTH, {2'($urandom_range(3)), 6'($urandom_range(24, 1))});
      queue_traffic(120);
      drain();

      send_idle_pct = 38;
      stall_pct = 38;
      write_reg(CSR_HEADER_BYTE, HEADER_RESET);
      write_reg(CSR_MAX_LENGTH, MAXLEN_RESET);
      queue_traffic(70);
      drain();
      queue_traffic(70);
      drain();

      // back-pressure: stall the receiver so that both frame slots fill
      send_idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_request = 300;
      repeat (4) begin
         open_frame(random_cmd(), 16);
         add_payload(16);
         close_frame(TAIL_GOOD);
      end
      drain();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
